[design/codepage_to_utf8_decoder_macros.svh]
// Assertion macros for the code-page to UTF-8 decoder.
// Used by the top level only; depends on a clk and arst_n in scope.
`ifndef CODEPAGE_TO_UTF8_DECODER_MACROS_SVH
`define CODEPAGE_TO_UTF8_DECODER_MACROS_SVH
`ifndef SYNTH
`define C2U_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("c2u: assertion failed");
`define C2U_NEVER(name, expr) \
	`C2U_ASSERT(name, !(expr))
`else
`define C2U_ASSERT(name, prop)
`define C2U_NEVER(name, expr)
`endif
`endif

[design/c2u_pkg.sv]
// Shared types, codes and the UTF-8 encoder for the code-page decoder.
// No dependencies.
`default_nettype none
package c2u_pkg;

	localparam int TableDepth = 256;
	localparam int QueueDepth = 2;
	localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// run status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_SUBST  = 2'd1;
	localparam logic [1:0] STATUS_FAILED = 2'd2;

	// error modes
	localparam logic [1:0] MODE_FAIL    = 2'd0;
	localparam logic [1:0] MODE_REPLACE = 2'd1;
	localparam logic [1:0] MODE_DROP    = 2'd2;

	// request types
	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_CONVERT = 1'b1;

	localparam logic [20:0] CpMax       = 21'h10FFFF;
	localparam logic [20:0] SurrFirst   = 21'h00D800;
	localparam logic [20:0] SurrLast    = 21'h00DFFF;
	localparam logic [7:0]  ReplByte0   = 8'hEF;
	localparam logic [7:0]  ReplByte1   = 8'hBF;
	localparam logic [7:0]  ReplByte2   = 8'hBD;

	// one queued word group: up to four output bytes for one input byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            present;
		logic [1:0]      status;
	} job_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} utf8_t;

	function automatic logic cp_ok(input logic [20:0] cp);
		return (cp <= CpMax) && !((cp >= SurrFirst) && (cp <= SurrLast));
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.bytes[0] = {1'b0, cp[6:0]};
			r.last_idx = 2'd0;
		end else if (cp < 21'h800) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.last_idx = 2'd1;
		end else if (cp < 21'h10000) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.last_idx = 2'd2;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.last_idx = 2'd3;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[design/codepage_to_utf8_decoder.sv]
// Top level of the single-byte code-page to UTF-8 decoder.
// Depends on c2u_pkg, c2u_front, c2u_queue, c2u_back and the macro header.
//
// Channel   Direction  Handshake            Word
// in        sink       in_valid/in_stall    one load or convert request
// out       source     out_valid/out_stall  one UTF-8 byte or a status-only word
// cfg       sink       cfg_wr_en            error_mode, written at once
//
// A convert request reads the table into the lookup stage and is classified as
// its job enters the queue; the single output register then drains one output
// word per cycle while not stalled, 1 to 4 words per byte. Loads give no output.
// Reset clears every table entry to invalid at once (valid bits in flops),
// error_mode to fail and the running status to success.
// A stalled output holds the queue; the input stalls only once the lookup
// stage is full and the queue cannot take its job.
`default_nettype none
`include "codepage_to_utf8_decoder_macros.svh"
module codepage_to_utf8_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic        start_of_text,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  table_index,
	input  wire logic [20:0] entry_code_point,
	input  wire logic        entry_valid,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_present,
	output logic             last_of_run,
	output logic [1:0]       status
);
	import c2u_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	// look up, classify and hand the job on
	c2u_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.start_of_text    (start_of_text),
		.byte_value       (byte_value),
		.table_index      (table_index),
		.entry_code_point (entry_code_point),
		.entry_valid      (entry_valid),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.q_push           (q_push),
		.q_job            (push_job),
		.q_full           (q_full)
	);

	// decouple the lookup from the byte walk
	c2u_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	// emit one byte per cycle unless the output stalls, drop the job after its last byte
	c2u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.last_of_run  (last_of_run),
		.status       (status)
	);

	// the front must never offer a job the queue cannot take
	`C2U_NEVER(a_push_when_full, q_push && q_full)
	// a status-only word always closes its run
	`C2U_ASSERT(a_statusonly_last, (out_valid && !byte_present) |-> last_of_run)
	// a failed word never carries a byte
	`C2U_ASSERT(a_failed_no_byte, (out_valid && status == STATUS_FAILED) |-> !byte_present)
	// popping needs a job at the head
	`C2U_NEVER(a_pop_when_empty, q_pop && q_empty)

endmodule
`default_nettype wire

[design/c2u_front.sv]
// Front part: mapping table, lookup stage, error-mode classification.
// Depends on c2u_pkg.
`default_nettype none
module c2u_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic              start_of_text,
	input  wire logic [7:0]        byte_value,
	input  wire logic [7:0]        table_index,
	input  wire logic [20:0]       entry_code_point,
	input  wire logic              entry_valid,
	input  wire logic              cfg_wr_en,
	input  wire logic [1:0]        cfg_wr_data,
	output logic                   q_push,
	output c2u_pkg::job_t          q_job,
	input  wire logic              q_full
);
	import c2u_pkg::*;

	logic [20:0]           cp_mem_q [TableDepth];
	logic [TableDepth-1:0] valid_q;
	logic [1:0]            error_mode_q;
	logic [1:0]            run_status_q;

	logic                  vld_s1;
	logic                  sot_s1;
	logic                  hit_s1;
	logic [20:0]           cp_s1;

	logic                  accept;
	logic                  conv_acc;
	logic                  load_wr;
	logic [1:0]            st0;
	logic [1:0]            st_next;
	utf8_t                 enc;

	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign conv_acc = accept && (req_type == REQ_CONVERT);
	assign load_wr  = accept && (req_type == REQ_LOAD) && !valid_q[table_index];
	assign q_push   = vld_s1 && !q_full;

	// first mapping wins: write only while the entry is still invalid
	always_ff @(posedge clk) begin
		if (load_wr)
			cp_mem_q[table_index] <= entry_code_point;
		if (conv_acc)
			cp_s1 <= cp_mem_q[byte_value];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			error_mode_q <= MODE_FAIL;
			run_status_q <= STATUS_OK;
			vld_s1       <= 1'b0;
			sot_s1       <= 1'b0;
			hit_s1       <= 1'b0;
		end else begin
			if (load_wr)
				valid_q[table_index] <= entry_valid;
			if (cfg_wr_en)
				error_mode_q <= cfg_wr_data;
			if (q_push)
				run_status_q <= st_next;
			if (conv_acc) begin
				vld_s1 <= 1'b1;
				sot_s1 <= start_of_text;
				hit_s1 <= valid_q[byte_value];
			end else if (q_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		st0           = sot_s1 ? STATUS_OK : run_status_q;
		enc           = utf8_encode(cp_s1);
		q_job.bytes   = '0;
		q_job.last_idx = 2'd0;
		q_job.present = 1'b0;
		q_job.status  = st0;
		st_next       = st0;
		if (st0 == STATUS_FAILED) begin
			q_job.status = STATUS_FAILED;
		end else if (hit_s1 && cp_ok(cp_s1)) begin
			q_job.bytes    = enc.bytes;
			q_job.last_idx = enc.last_idx;
			q_job.present  = 1'b1;
		end else if (error_mode_q == MODE_FAIL) begin
			q_job.status = STATUS_FAILED;
			st_next      = STATUS_FAILED;
		end else if (error_mode_q == MODE_REPLACE) begin
			q_job.bytes[0] = ReplByte0;
			q_job.bytes[1] = ReplByte1;
			q_job.bytes[2] = ReplByte2;
			q_job.last_idx = 2'd2;
			q_job.present  = 1'b1;
			q_job.status   = STATUS_SUBST;
			st_next        = STATUS_SUBST;
		end else begin
			q_job.status = STATUS_SUBST;
			st_next      = STATUS_SUBST;
		end
	end

endmodule
`default_nettype wire

[design/c2u_queue.sv]
// Short job queue between the front and back parts.
// Depends on c2u_pkg.
`default_nettype none
module c2u_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire c2u_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output c2u_pkg::job_t      head_job,
	output logic               empty
);
	import c2u_pkg::*;

	job_t             slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == QCntW'(QueueDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[design/c2u_back.sv]
// Back part: walks the head job byte by byte into the output register.
// Depends on c2u_pkg.
`default_nettype none
module c2u_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire c2u_pkg::job_t head_job,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               byte_present,
	output logic               last_of_run,
	output logic [1:0]         status
);
	import c2u_pkg::*;

	logic [1:0] k_q;
	logic       load_out;
	logic       emit;
	logic       is_last;

	assign load_out = !out_valid || !out_stall;
	assign emit     = load_out && !q_empty;
	assign is_last  = (k_q == head_job.last_idx);
	assign q_pop    = emit && is_last;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte     <= head_job.bytes[k_q];
			byte_present <= head_job.present;
			last_of_run  <= is_last;
			status       <= head_job.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			k_q       <= 2'd0;
		end else begin
			if (load_out)
				out_valid <= !q_empty;
			if (emit)
				k_q <= is_last ? 2'd0 : k_q + 2'd1;
		end
	end

endmodule
`default_nettype wire
